>>> src/circular_deque_top_defines.svh
// assertion macros shared by the deque checker
// depends on nothing; include once per file that asserts
`ifndef CIRCULAR_DEQUE_TOP_DEFINES_SVH
`define CIRCULAR_DEQUE_TOP_DEFINES_SVH

// same-cycle implication, sampled on the rising edge, idle during reset
`define CDQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deque check failed");

// next-cycle implication
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deque check failed");

`endif

>>> src/cdq_pkg.sv
// operation codes, word constants and the result record of the deque
// no dependencies
`default_nettype none

package cdq_pkg;

	localparam int WORD_W = 32;

	localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [2:0] OP_POP_FRONT  = 3'd2;
	localparam logic [2:0] OP_POP_BACK   = 3'd3;
	localparam logic [2:0] OP_STATUS     = 3'd4;

	localparam logic signed [WORD_W-1:0] EMPTY_WORD = '1;

	typedef struct packed {
		logic signed [WORD_W-1:0] popped_value;
		logic                     pop_on_empty;
		logic                     push_dropped;
		logic                     is_empty;
		logic signed [WORD_W-1:0] front_value;
		logic signed [WORD_W-1:0] back_value;
	} res_t;

endpackage

`default_nettype wire

>>> src/cdq_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module cdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> src/cdq_core.sv
// deque state: ring pointers, count, cached end words and the ring ram
// depends on cdq_pkg and cdq_ram
`default_nettype none

module cdq_core #(
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_fire,
	input  wire logic [2:0]                          operation,
	input  wire logic signed [cdq_pkg::WORD_W-1:0]   value_in,
	output cdq_pkg::res_t                            res,
	output logic [CW-1:0]                            res_count
);

	// the two words at each end are held in flops; the ram only refills
	// the second word of an end after a pop from that end
	logic [AW-1:0] head_q, tail_q, head_n, tail_n;
	logic [CW-1:0] count_q, count_n;
	logic signed [cdq_pkg::WORD_W-1:0] f0_q, f1_q, b0_q, b1_q;
	logic signed [cdq_pkg::WORD_W-1:0] f0_n, f1_n, b0_n, b1_n;
	logic signed [cdq_pkg::WORD_W-1:0] f1_eff, b1_eff;
	logic f1_pend_q, b1_pend_q, f1_pend_n, b1_pend_n;

	logic                              ram_we, ram_re;
	logic [AW-1:0]                     ram_waddr, ram_raddr;
	logic [cdq_pkg::WORD_W-1:0]        ram_rdata;

	logic is_full, is_zero, is_one;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
		return (p == '0) ? AW'(DEPTH - 1) : p - 1'b1;
	endfunction

	cdq_ram #(
		.WIDTH(cdq_pkg::WORD_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(value_in),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// refilled word arrives from the ram in the cycle after the pop
	assign f1_eff = f1_pend_q ? signed'(ram_rdata) : f1_q;
	assign b1_eff = b1_pend_q ? signed'(ram_rdata) : b1_q;

	assign is_full = (count_q == CW'(DEPTH));
	assign is_zero = (count_q == '0);
	assign is_one  = (count_q == CW'(1));

	always_comb begin
		head_n    = head_q;
		tail_n    = tail_q;
		count_n   = count_q;
		f0_n      = f0_q;
		f1_n      = f1_eff;
		b0_n      = b0_q;
		b1_n      = b1_eff;
		f1_pend_n = 1'b0;
		b1_pend_n = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = ptr_dec(head_q);
		ram_re    = 1'b0;
		ram_raddr = ptr_inc(ptr_inc(head_q));
		res.popped_value = cdq_pkg::EMPTY_WORD;
		res.pop_on_empty = 1'b0;
		res.push_dropped = 1'b0;
		if (in_fire) begin
			unique case (operation)
				cdq_pkg::OP_PUSH_FRONT: begin
					if (is_full) begin
						res.push_dropped = 1'b1;
					end else begin
						head_n  = ptr_dec(head_q);
						count_n = count_q + 1'b1;
						ram_we  = 1'b1;
						f0_n    = value_in;
						f1_n    = f0_q;
						if (is_zero) begin
							b0_n = value_in;
						end
						if (is_one) begin
							b1_n = value_in;
						end
					end
				end
				cdq_pkg::OP_PUSH_BACK: begin
					if (is_full) begin
						res.push_dropped = 1'b1;
					end else begin
						tail_n    = ptr_inc(tail_q);
						count_n   = count_q + 1'b1;
						ram_we    = 1'b1;
						ram_waddr = tail_q;
						b0_n      = value_in;
						b1_n      = b0_q;
						if (is_zero) begin
							f0_n = value_in;
						end
						if (is_one) begin
							f1_n = value_in;
						end
					end
				end
				cdq_pkg::OP_POP_FRONT: begin
					if (is_zero) begin
						res.pop_on_empty = 1'b1;
					end else begin
						res.popped_value = f0_q;
						head_n    = ptr_inc(head_q);
						count_n   = count_q - 1'b1;
						f0_n      = f1_eff;
						ram_re    = 1'b1;
						f1_pend_n = 1'b1;
					end
				end
				cdq_pkg::OP_POP_BACK: begin
					if (is_zero) begin
						res.pop_on_empty = 1'b1;
					end else begin
						res.popped_value = b0_q;
						tail_n    = ptr_dec(tail_q);
						count_n   = count_q - 1'b1;
						b0_n      = b1_eff;
						ram_re    = 1'b1;
						ram_raddr = ptr_dec(ptr_dec(ptr_dec(tail_q)));
						b1_pend_n = 1'b1;
					end
				end
				default: begin
					// status and unused codes leave the state alone
				end
			endcase
		end
		res.is_empty    = (count_n == '0);
		res.front_value = res.is_empty ? cdq_pkg::EMPTY_WORD : f0_n;
		res.back_value  = res.is_empty ? cdq_pkg::EMPTY_WORD : b0_n;
		res_count       = count_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			f1_pend_q <= 1'b0;
			b1_pend_q <= 1'b0;
		end else begin
			head_q    <= head_n;
			tail_q    <= tail_n;
			count_q   <= count_n;
			f1_pend_q <= f1_pend_n;
			b1_pend_q <= b1_pend_n;
		end
	end

	always_ff @(posedge clk) begin
		f0_q <= f0_n;
		f1_q <= f1_n;
		b0_q <= b0_n;
		b1_q <= b1_n;
	end

endmodule

`default_nettype wire

>>> src/circular_deque_top.sv
// latency: a result is valid the cycle after its item transfers
// throughput: one item per cycle while no waiting result is held back; the ring ram takes one write or one read a cycle
// the end words are held in flops, so a pop refills its end from the ram in the next cycle
// reset: asynchronous, active low; pointers and count go to zero, the deque is empty
// ram contents are not cleared and need no clearing pass
`default_nettype none

module circular_deque_top #(
	parameter int DEPTH = 1024,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [2:0]                        operation,
	input  wire logic signed [cdq_pkg::WORD_W-1:0] value_in,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed [cdq_pkg::WORD_W-1:0]      popped_value,
	output logic                                   pop_on_empty,
	output logic                                   push_dropped,
	output logic [CW-1:0]                          entry_count,
	output logic                                   is_empty,
	output logic signed [cdq_pkg::WORD_W-1:0]      front_value,
	output logic signed [cdq_pkg::WORD_W-1:0]      back_value
);

	logic          in_fire;
	cdq_pkg::res_t res_n, res_q;
	logic [CW-1:0] count_n, count_q;
	logic          out_valid_q;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	cdq_core #(
		.DEPTH(DEPTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.operation(operation),
		.value_in (value_in),
		.res      (res_n),
		.res_count(count_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_q   <= res_n;
			count_q <= count_n;
		end
	end

	assign out_valid    = out_valid_q;
	assign popped_value = res_q.popped_value;
	assign pop_on_empty = res_q.pop_on_empty;
	assign push_dropped = res_q.push_dropped;
	assign entry_count  = count_q;
	assign is_empty     = res_q.is_empty;
	assign front_value  = res_q.front_value;
	assign back_value   = res_q.back_value;

endmodule

`default_nettype wire

>>> src/cdq_checker.sv
// port-level checks on the deque input and result streams, bound to the top level
// depends on circular_deque_top_defines.svh
`default_nettype none
`include "circular_deque_top_defines.svh"

module cdq_checker #(
	parameter int DEPTH = 1024,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic [2:0]         operation,
	input wire logic signed [31:0] value_in,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic signed [31:0] popped_value,
	input wire logic               pop_on_empty,
	input wire logic               push_dropped,
	input wire logic [CW-1:0]      entry_count,
	input wire logic               is_empty,
	input wire logic signed [31:0] front_value,
	input wire logic signed [31:0] back_value
);

	// a waiting input item keeps its valid and payload
	`CDQ_ASSERT_NEXT(a_in_hold, clk, arst_n, in_valid && !in_ready,
		in_valid && $stable(operation) && $stable(value_in))

	// a waiting result stays up
	`CDQ_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)

	`CDQ_ASSERT_NOW(a_empty_count, clk, arst_n, out_valid, is_empty == (entry_count == '0))

	// an empty deque shows all ones at both ends
	`CDQ_ASSERT_NOW(a_empty_ends, clk, arst_n, out_valid && is_empty,
		front_value == -32'sd1 && back_value == -32'sd1)

	// a refused pop leaves nothing held and pops nothing
	`CDQ_ASSERT_NOW(a_pop_empty, clk, arst_n, out_valid && pop_on_empty,
		is_empty && !push_dropped && popped_value == -32'sd1)

endmodule

bind circular_deque_top cdq_checker #(.DEPTH(DEPTH)) u_cdq_checker (.*);

`default_nettype wire

>>> test/tb.sv
// self-checking testbench for circular_deque_top: front/back push and pop, status, full and empty
// depends on cdq_pkg (operation codes, word width, empty word) and the circular_deque_top rtl
// results are predicted from a behavioral deque and checked in order as they transfer

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WORD_W = cdq_pkg::WORD_W;
	localparam int RING_DEPTH = 1024;
	localparam int CW = $clog2(RING_DEPTH + 1);
	localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0] OP_SPARE_MID = 3'd6;
	localparam logic [2:0] OP_SPARE_LAST = 3'd7;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_SHOWN = 10;

	typedef struct packed {
		logic signed [WORD_W-1:0] popped;
		logic                     pop_empty;
		logic                     dropped;
		logic [CW-1:0]            count;
		logic                     empty;
		logic signed [WORD_W-1:0] front;
		logic signed [WORD_W-1:0] back;
	} deque_result_t;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic [2:0]               operation;
	logic signed [WORD_W-1:0] value_in;
	logic                     out_valid;
	logic                     out_ready;
	logic signed [WORD_W-1:0] popped_value;
	logic                     pop_on_empty;
	logic                     push_dropped;
	logic [CW-1:0]            entry_count;
	logic                     is_empty;
	logic signed [WORD_W-1:0] front_value;
	logic signed [WORD_W-1:0] back_value;

	// behavioral copy of the deque
	logic signed [WORD_W-1:0] ring_words [RING_DEPTH];
	int head_pos;
	int tail_pos;
	int words_held;

	deque_result_t pending_results[$];
	bit idle_on;
	int mismatches;
	int items_sent;
	int results_seen;
	int drops_predicted;
	int empty_pops_predicted;
	int cycles;
	int stall_left;

	circular_deque_top #(.DEPTH(RING_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.value_in(value_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.popped_value(popped_value),
		.pop_on_empty(pop_on_empty),
		.push_dropped(push_dropped),
		.entry_count(entry_count),
		.is_empty(is_empty),
		.front_value(front_value),
		.back_value(back_value)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_results.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic deque_result_t apply_deque_op(input logic [2:0] op,
			input logic signed [WORD_W-1:0] word);
		deque_result_t r;
		r.popped = cdq_pkg::EMPTY_WORD;
		r.pop_empty = 1'b0;
		r.dropped = 1'b0;
		case (op)
			cdq_pkg::OP_PUSH_FRONT: begin
				if (words_held == RING_DEPTH) begin
					r.dropped = 1'b1;
				end else begin
					head_pos = (head_pos + RING_DEPTH - 1) % RING_DEPTH;
					ring_words[head_pos] = word;
					words_held++;
				end
			end
			cdq_pkg::OP_PUSH_BACK: begin
				if (words_held == RING_DEPTH) begin
					r.dropped = 1'b1;
				end else begin
					ring_words[tail_pos] = word;
					tail_pos = (tail_pos + 1) % RING_DEPTH;
					words_held++;
				end
			end
			cdq_pkg::OP_POP_FRONT: begin
				if (words_held == 0) begin
					r.pop_empty = 1'b1;
				end else begin
					r.popped = ring_words[head_pos];
					head_pos = (head_pos + 1) % RING_DEPTH;
					words_held--;
				end
			end
			cdq_pkg::OP_POP_BACK: begin
				if (words_held == 0) begin
					r.pop_empty = 1'b1;
				end else begin
					tail_pos = (tail_pos + RING_DEPTH - 1) % RING_DEPTH;
					r.popped = ring_words[tail_pos];
					words_held--;
				end
			end
			default: begin
				// status and the spare codes leave the deque alone
			end
		endcase
		r.count = CW'(words_held);
		r.empty = (words_held == 0);
		r.front = (words_held != 0) ? ring_words[head_pos] : cdq_pkg::EMPTY_WORD;
		r.back = (words_held != 0) ? ring_words[(tail_pos + RING_DEPTH - 1) % RING_DEPTH]
			: cdq_pkg::EMPTY_WORD;
		return r;
	endfunction

	task automatic send_item(input logic [2:0] op, input logic signed [WORD_W-1:0] word);
		deque_result_t want;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		value_in <= word;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		want = apply_deque_op(op, word);
		pending_results.push_back(want);
		items_sent++;
		if (want.dropped) drops_predicted++;
		if (want.pop_empty) empty_pops_predicted++;
		@(negedge clk);
	endtask

	// receiver stalls in bursts
	initial begin
		forever begin
			@(negedge clk);
			if (stall_left > 0)
				stall_left--;
			else if (idle_on && $urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 11);
			out_ready <= (stall_left == 0);
		end
	end

	task automatic flag_field(input string field, input logic [WORD_W-1:0] want,
			input logic [WORD_W-1:0] got);
		mismatches++;
		if (mismatches <= MAX_SHOWN)
			$display("mismatch on result %0d, %s: expected %h, got %h", results_seen, field,
				want, got);
	endtask

	always @(posedge clk) begin : result_check
		deque_result_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("result %0d transferred with nothing expected", results_seen);
			end else begin
				want = pending_results.pop_front();
				if (popped_value !== want.popped)
					flag_field("popped_value", want.popped, popped_value);
				if (pop_on_empty !== want.pop_empty)
					flag_field("pop_on_empty", WORD_W'(want.pop_empty),
						WORD_W'(pop_on_empty));
				if (push_dropped !== want.dropped)
					flag_field("push_dropped", WORD_W'(want.dropped),
						WORD_W'(push_dropped));
				if (entry_count !== want.count)
					flag_field("entry_count", WORD_W'(want.count), WORD_W'(entry_count));
				if (is_empty !== want.empty)
					flag_field("is_empty", WORD_W'(want.empty), WORD_W'(is_empty));
				if (front_value !== want.front)
					flag_field("front_value", want.front, front_value);
				if (back_value !== want.back)
					flag_field("back_value", want.back, back_value);
			end
		end
	end

	function automatic logic signed [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return {1'b1, {(WORD_W-1){1'b0}}};
			1: return {1'b0, {(WORD_W-1){1'b1}}};
			2: return cdq_pkg::EMPTY_WORD;
			3: return '0;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [2:0] pick_push();
		return $urandom_range(0, 1) ? cdq_pkg::OP_PUSH_BACK : cdq_pkg::OP_PUSH_FRONT;
	endfunction

	function automatic logic [2:0] pick_pop();
		return $urandom_range(0, 1) ? cdq_pkg::OP_POP_BACK : cdq_pkg::OP_POP_FRONT;
	endfunction

	task automatic test_directed();
		idle_on = 1'b1;
		send_item(cdq_pkg::OP_STATUS, $urandom);
		send_item(cdq_pkg::OP_POP_FRONT, $urandom);
		send_item(cdq_pkg::OP_POP_BACK, $urandom);
		send_item(OP_SPARE_FIRST, $urandom);
		// head wraps below zero on the first front push
		send_item(cdq_pkg::OP_PUSH_FRONT, {1'b1, {(WORD_W-1){1'b0}}});
		send_item(cdq_pkg::OP_PUSH_BACK, {1'b0, {(WORD_W-1){1'b1}}});
		// a stored all-ones word looks like the empty marker
		send_item(cdq_pkg::OP_PUSH_FRONT, cdq_pkg::EMPTY_WORD);
		send_item(cdq_pkg::OP_PUSH_BACK, '0);
		send_item(cdq_pkg::OP_STATUS, '0);
		send_item(cdq_pkg::OP_POP_BACK, '1);
		send_item(cdq_pkg::OP_POP_FRONT, '1);
		send_item(cdq_pkg::OP_POP_FRONT, '0);
		send_item(cdq_pkg::OP_POP_BACK, '0);
		send_item(cdq_pkg::OP_POP_BACK, '0);
		send_item(cdq_pkg::OP_PUSH_BACK, 32'h5555_5555);
		send_item(cdq_pkg::OP_PUSH_BACK, 32'haaaa_aaaa);
		send_item(OP_SPARE_MID, 32'h1234_5678);
		send_item(OP_SPARE_LAST, '1);
		send_item(cdq_pkg::OP_POP_FRONT, '0);
		send_item(cdq_pkg::OP_POP_FRONT, '0);
		send_item(cdq_pkg::OP_PUSH_FRONT, 32'h0000_0001);
		send_item(cdq_pkg::OP_POP_BACK, '0);
	endtask

	task automatic test_random_mix(input int n);
		int r;
		for (int i = 0; i < n; i++) begin
			// stretches with and without idling
			if (i % 100 == 0) idle_on = ($urandom_range(0, 3) != 0);
			r = $urandom_range(0, 99);
			if (r < 40)
				send_item(pick_push(), pick_word());
			else if (r < 80)
				send_item(pick_pop(), pick_word());
			else if (r < 92)
				send_item(cdq_pkg::OP_STATUS, pick_word());
			else
				send_item(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), pick_word());
		end
	endtask

	task automatic test_fill_and_drain();
		idle_on = 1'b1;
		while (words_held < RING_DEPTH) begin
			if ($urandom_range(0, 31) == 0)
				send_item(cdq_pkg::OP_STATUS, pick_word());
			else
				send_item(pick_push(), pick_word());
		end
		// refused pushes at both ends while full
		send_item(cdq_pkg::OP_PUSH_FRONT, pick_word());
		send_item(cdq_pkg::OP_PUSH_BACK, pick_word());
		send_item(pick_push(), pick_word());
		send_item(cdq_pkg::OP_STATUS, pick_word());
		send_item(pick_pop(), pick_word());
		send_item(pick_push(), pick_word());
		send_item(pick_push(), pick_word());
		// pull words off both ends just below the full mark
		while (words_held > RING_DEPTH - 32) begin
			if ($urandom_range(0, 15) == 0)
				send_item(cdq_pkg::OP_STATUS, pick_word());
			else
				send_item(pick_pop(), pick_word());
		end
	endtask

	task automatic test_random_mix_no_idle(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 1))
				send_item(pick_push(), pick_word());
			else
				send_item(3'($urandom_range(cdq_pkg::OP_POP_FRONT, OP_SPARE_LAST)),
					pick_word());
		end
	endtask

	task automatic test_full_rate(input int n);
		idle_on = 1'b0;
		test_random_mix_no_idle(n);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = cdq_pkg::OP_STATUS;
		value_in = '0;
		out_ready = 1'b0;
		idle_on = 1'b0;
		head_pos = 0;
		tail_pos = 0;
		words_held = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_random_mix(100);
		test_fill_and_drain();
		test_full_rate(100);

		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);

		$display("%0d operations sent, %0d results checked, %0d refused pushes, %0d empty pops",
			items_sent, results_seen, drops_predicted, empty_pops_predicted);
		$display("deque filled to %0d words with refused pushes, stalls on both channels",
			RING_DEPTH);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+src
src/cdq_pkg.sv
src/cdq_ram.sv
src/cdq_core.sv
src/circular_deque_top.sv
src/cdq_checker.sv
test/tb.sv
